// ===== rtl/core/kolp_pkg.sv =====
`default_nettype none
package kolp_pkg;

  localparam logic [7:0]  DEFAULT_HMAC_LEN_RST = 8'd10;
  localparam logic [15:0] TYPE_HMAC     = 16'h001a;
  localparam logic [15:0] TYPE_SSEQ     = 16'h001e;
  localparam int unsigned FLAG_REQUIRE  = 0;
  localparam int unsigned FLAG_SEND     = 2;
  localparam logic [15:0] MAC_LEN_MIN   = 16'd4;
  localparam logic [15:0] MAC_LEN_MAX   = 16'd32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  mac_flags;
    logic [7:0]  seq_flags;
    logic [15:0] offered_hmac_len;
    logic        mac_tx_en;
    logic        mac_rx_en;
    logic        seq_tx_en;
    logic        seq_rx_en;
    logic [7:0]  rx_mac_len;
  } out_word_t;

  // 7-bit group VLU accumulate, saturating at 16 bits
  function automatic logic [15:0] vlu_add(logic [15:0] acc, logic [7:0] b);
    logic [22:0] v;
    v = {acc, b[6:0]};
    return (v[22:16] != 7'd0) ? 16'hffff : v[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kolp_parser.sv =====
`default_nettype none
module kolp_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               byte_fire,
  input  wire kolp_pkg::in_word_t in_data,
  input  wire logic [7:0]         default_hmac_len,
  output logic                    res_valid,
  output kolp_pkg::out_word_t     res
);

  localparam logic [2:0] PH_LEN   = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_FIRST = 3'd2;
  localparam logic [2:0] PH_REST  = 3'd3;
  localparam logic [2:0] PH_STOP  = 3'd4;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_HMAC  = 2'd1;
  localparam logic [1:0] KIND_SSEQ  = 2'd2;

  localparam logic [1:0] LS_NONE = 2'd0;
  localparam logic [1:0] LS_BUSY = 2'd1;
  localparam logic [1:0] LS_DONE = 2'd2;

  logic [2:0]  phase_r,      phase_nxt;
  logic [15:0] vlu_r,        vlu_nxt;
  logic [15:0] left_r,       left_nxt;
  logic [15:0] tcount_r,     tcount_nxt;
  logic [1:0]  kind_r,       kind_nxt;
  logic [7:0]  pflags_r,     pflags_nxt;
  logic [15:0] plen_r,       plen_nxt;
  logic [1:0]  lstate_r,     lstate_nxt;
  logic [7:0]  hflags_r,     hflags_nxt;
  logic [7:0]  sflags_r,     sflags_nxt;
  logic [15:0] hlen_r,       hlen_nxt;

  logic       more;
  logic       fin;
  logic [2:0] fin_phase;

  assign more = in_data.data_byte[7];

  always_comb begin
    phase_nxt  = phase_r;
    vlu_nxt    = vlu_r;
    left_nxt   = left_r;
    tcount_nxt = tcount_r;
    kind_nxt   = kind_r;
    pflags_nxt = pflags_r;
    plen_nxt   = plen_r;
    lstate_nxt = lstate_r;
    hflags_nxt = hflags_r;
    sflags_nxt = sflags_r;
    hlen_nxt   = hlen_r;
    fin        = 1'b0;
    fin_phase  = PH_LEN;

    case (phase_r)
      PH_LEN: begin
        vlu_nxt = kolp_pkg::vlu_add(vlu_r, in_data.data_byte);
        if (!more) begin
          if (vlu_nxt == 16'd0) begin
            phase_nxt = PH_STOP;
          end else begin
            left_nxt   = vlu_nxt;
            vlu_nxt    = 16'd0;
            tcount_nxt = 16'd0;
            phase_nxt  = PH_TYPE;
          end
        end
      end
      PH_TYPE: begin
        vlu_nxt    = kolp_pkg::vlu_add(vlu_r, in_data.data_byte);
        tcount_nxt = tcount_r + {15'd0, (tcount_r != 16'hffff)};
        if (!more) begin
          if (vlu_nxt == kolp_pkg::TYPE_HMAC) begin
            kind_nxt = KIND_HMAC;
          end else if (vlu_nxt == kolp_pkg::TYPE_SSEQ) begin
            kind_nxt = KIND_SSEQ;
          end else begin
            kind_nxt = KIND_OTHER;
          end
          if (tcount_nxt > left_r) begin
            phase_nxt = PH_STOP;
          end else begin
            left_nxt   = left_r - tcount_nxt;
            pflags_nxt = 8'd0;
            plen_nxt   = 16'd0;
            lstate_nxt = LS_NONE;
            if (left_nxt == 16'd0) begin
              kind_nxt = KIND_OTHER;
              fin      = 1'b1;
            end else begin
              phase_nxt = PH_FIRST;
            end
          end
        end
      end
      PH_FIRST: begin
        pflags_nxt = in_data.data_byte;
        left_nxt   = left_r - 16'd1;
        phase_nxt  = PH_REST;
        fin        = (left_nxt == 16'd0);
      end
      PH_REST: begin
        if (kind_r == KIND_HMAC && lstate_r != LS_DONE) begin
          plen_nxt   = kolp_pkg::vlu_add(plen_r, in_data.data_byte);
          lstate_nxt = more ? LS_BUSY : LS_DONE;
        end
        left_nxt = left_r - 16'd1;
        fin      = (left_nxt == 16'd0);
      end
      default: begin
      end
    endcase

    // option complete: commit it
    if (fin) begin
      if (kind_nxt == KIND_HMAC) begin
        hflags_nxt = pflags_nxt;
        if (lstate_nxt == LS_DONE) begin
          hlen_nxt = plen_nxt;
        end else if (lstate_nxt == LS_BUSY) begin
          fin_phase = PH_STOP;
        end
      end else if (kind_nxt == KIND_SSEQ) begin
        sflags_nxt = pflags_nxt;
      end
      phase_nxt = fin_phase;
      vlu_nxt   = 16'd0;
    end
  end

  assign res_valid = byte_fire && in_data.last_byte;

  always_comb begin
    res.mac_flags        = hflags_nxt;
    res.seq_flags        = sflags_nxt;
    res.offered_hmac_len = hlen_nxt;
    res.mac_tx_en        = hflags_nxt[kolp_pkg::FLAG_REQUIRE];
    res.mac_rx_en        = hflags_nxt[kolp_pkg::FLAG_SEND];
    res.seq_tx_en        = sflags_nxt[kolp_pkg::FLAG_REQUIRE];
    res.seq_rx_en        = sflags_nxt[kolp_pkg::FLAG_SEND];
    res.rx_mac_len       = (hlen_nxt >= kolp_pkg::MAC_LEN_MIN &&
                            hlen_nxt <= kolp_pkg::MAC_LEN_MAX) ?
                           hlen_nxt[7:0] : default_hmac_len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      phase_r  <= PH_LEN;
      vlu_r    <= 16'd0;
      left_r   <= 16'd0;
      tcount_r <= 16'd0;
      kind_r   <= KIND_OTHER;
      pflags_r <= 8'd0;
      plen_r   <= 16'd0;
      lstate_r <= LS_NONE;
      hflags_r <= 8'd0;
      sflags_r <= 8'd0;
      hlen_r   <= 16'd0;
    end else if (byte_fire) begin
      phase_r  <= phase_nxt;
      vlu_r    <= vlu_nxt;
      left_r   <= left_nxt;
      tcount_r <= tcount_nxt;
      kind_r   <= kind_nxt;
      pflags_r <= pflags_nxt;
      plen_r   <= plen_nxt;
      lstate_r <= lstate_nxt;
      hflags_r <= hflags_nxt;
      sflags_r <= sflags_nxt;
      hlen_r   <= hlen_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/keying_option_list_parser.sv =====
// Output: the result word is registered into out_data, or into the skid entry
//   while out_data holds an unaccepted word, on accepting the last_byte word.
// Throughput: one input word per cycle while the skid is empty; parser state is
//   updated in the accept cycle, results pass a two-entry output register/skid.
// Reset (rst_n low, synchronous): parser state cleared, output empty,
//   default_hmac_len back to 10.
`default_nettype none
module keying_option_list_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire kolp_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output kolp_pkg::out_word_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [7:0]          cfg_data
);

  logic [7:0]          def_len_r;
  logic                res_valid;
  kolp_pkg::out_word_t res;

  logic                out_valid_r,  out_valid_nxt;
  kolp_pkg::out_word_t out_r,        out_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  kolp_pkg::out_word_t skid_r,       skid_nxt;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_len_r <= kolp_pkg::DEFAULT_HMAC_LEN_RST;
    end else if (cfg_valid) begin
      def_len_r <= cfg_data;
    end
  end

  kolp_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .byte_fire        (in_valid && in_ready),
    .in_data          (in_data),
    .default_hmac_len (def_len_r),
    .res_valid        (res_valid),
    .res              (res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (out_valid_r && out_ready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (res_valid) begin
      if (!out_valid_nxt) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== test/option_report_checker.sv =====
module option_report_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire kolp_pkg::in_word_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire kolp_pkg::out_word_t out_data,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [7:0]          cfg_data,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {S_LEN, S_TYPE, S_FLAGS, S_BODY, S_HALT} scan_state_t;
  typedef enum logic [1:0] {OPT_OTHER, OPT_HMAC, OPT_SSEQ} opt_kind_t;
  typedef enum logic [1:0] {HL_IDLE, HL_PART, HL_DONE} mac_len_state_t;

  scan_state_t     state;
  opt_kind_t       kind;
  mac_len_state_t  len_st;
  logic [15:0]     acc;
  logic [15:0]     remain;
  logic [15:0]     type_cnt;
  logic [7:0]      flags_p;
  logic [15:0]     len_p;
  logic [7:0]      hmac_f;
  logic [7:0]      sseq_f;
  logic [15:0]     kept_len;
  logic [7:0]      dflt_len;

  kolp_pkg::out_word_t report_q[$];
  kolp_pkg::out_word_t want;

  function automatic logic [15:0] grow_vlu(logic [15:0] a, logic [7:0] b);
    logic [31:0] wide;
    wide = {16'd0, a} * 32'd128 + {25'd0, b[6:0]};
    if (wide > 32'd65535) return 16'hffff;
    return wide[15:0];
  endfunction

  function automatic void clear_list();
    state    = S_LEN;
    kind     = OPT_OTHER;
    len_st   = HL_IDLE;
    acc      = '0;
    remain   = '0;
    type_cnt = '0;
    flags_p  = '0;
    len_p    = '0;
    hmac_f   = '0;
    sseq_f   = '0;
    kept_len = '0;
  endfunction

  function automatic void close_option();
    scan_state_t nxt;
    nxt = S_LEN;
    if (kind == OPT_HMAC) begin
      hmac_f = flags_p;
      if (len_st == HL_DONE) kept_len = len_p;
      else if (len_st == HL_PART) nxt = S_HALT;
    end else if (kind == OPT_SSEQ) begin
      sseq_f = flags_p;
    end
    state = nxt;
    acc   = '0;
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    logic cont;
    cont = b[7];
    case (state)
      S_LEN: begin
        acc = grow_vlu(acc, b);
        if (!cont) begin
          if (acc == 16'd0) begin
            state = S_HALT;
          end else begin
            remain   = acc;
            acc      = '0;
            type_cnt = '0;
            state    = S_TYPE;
          end
        end
      end
      S_TYPE: begin
        acc = grow_vlu(acc, b);
        if (type_cnt != 16'hffff) type_cnt = type_cnt + 16'd1;
        if (!cont) begin
          if (acc == kolp_pkg::TYPE_HMAC) kind = OPT_HMAC;
          else if (acc == kolp_pkg::TYPE_SSEQ) kind = OPT_SSEQ;
          else kind = OPT_OTHER;
          if (type_cnt > remain) begin
            state = S_HALT;
          end else begin
            remain  = remain - type_cnt;
            flags_p = '0;
            len_p   = '0;
            len_st  = HL_IDLE;
            if (remain == 16'd0) begin
              kind = OPT_OTHER;
              close_option();
            end else begin
              state = S_FLAGS;
            end
          end
        end
      end
      S_FLAGS: begin
        flags_p = b;
        remain  = remain - 16'd1;
        state   = S_BODY;
        if (remain == 16'd0) close_option();
      end
      S_BODY: begin
        if (kind == OPT_HMAC && len_st != HL_DONE) begin
          len_p = grow_vlu(len_p, b);
          if (cont) len_st = HL_PART;
          else len_st = HL_DONE;
        end
        remain = remain - 16'd1;
        if (remain == 16'd0) close_option();
      end
      default: ;
    endcase
  endfunction

  function automatic kolp_pkg::out_word_t make_report();
    kolp_pkg::out_word_t r;
    r.mac_flags        = hmac_f;
    r.seq_flags        = sseq_f;
    r.offered_hmac_len = kept_len;
    r.mac_tx_en        = hmac_f[kolp_pkg::FLAG_REQUIRE];
    r.mac_rx_en        = hmac_f[kolp_pkg::FLAG_SEND];
    r.seq_tx_en        = sseq_f[kolp_pkg::FLAG_REQUIRE];
    r.seq_rx_en        = sseq_f[kolp_pkg::FLAG_SEND];
    if (kept_len >= kolp_pkg::MAC_LEN_MIN && kept_len <= kolp_pkg::MAC_LEN_MAX)
      r.rx_mac_len = kept_len[7:0];
    else
      r.rx_mac_len = dflt_len;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      dflt_len = kolp_pkg::DEFAULT_HMAC_LEN_RST;
      clear_list();
      report_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $display("%0t: result word expected none got %h", $time, out_data);
          fail_count++;
        end else begin
          want = report_q.pop_front();
          check_field("mac_flags", {8'd0, want.mac_flags}, {8'd0, out_data.mac_flags});
          check_field("seq_flags", {8'd0, want.seq_flags}, {8'd0, out_data.seq_flags});
          check_field("offered_hmac_len", want.offered_hmac_len, out_data.offered_hmac_len);
          check_field("mac_tx_en", {15'd0, want.mac_tx_en}, {15'd0, out_data.mac_tx_en});
          check_field("mac_rx_en", {15'd0, want.mac_rx_en}, {15'd0, out_data.mac_rx_en});
          check_field("seq_tx_en", {15'd0, want.seq_tx_en}, {15'd0, out_data.seq_tx_en});
          check_field("seq_rx_en", {15'd0, want.seq_rx_en}, {15'd0, out_data.seq_rx_en});
          check_field("rx_mac_len", {8'd0, want.rx_mac_len}, {8'd0, out_data.rx_mac_len});
        end
      end
      if (cfg_valid && cfg_ready) dflt_len = cfg_data;
      if (in_valid && in_ready) begin
        parse_byte(in_data.data_byte);
        if (in_data.last_byte) begin
          report_q.insert(report_q.size(), make_report());
          clear_list();
        end
      end
    end
    pending = report_q.size();
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 4;
  localparam int PHASE_WORDS = 325;
  localparam int NUM_PHASES  = 6;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  kolp_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_ready;
  kolp_pkg::out_word_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [7:0]          cfg_data;
  int                  fail_count;
  int                  pending;
  bit                  hold_req = 1'b0;

  kolp_pkg::in_word_t word_q[$];
  logic [7:0] list_b[$];
  logic [7:0] typ_b[$];
  logic [7:0] val_b[$];
  logic [7:0] vlu_b[$];

  always #2 clk = ~clk;

  keying_option_list_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  option_report_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // VLU encoding, most significant group first, optional leading empty groups
  task automatic enc_vlu(input logic [15:0] v, input int pad);
    int n;
    int k;
    logic [15:0] g;
    vlu_b.delete();
    n = 1;
    while (n < 3 && (v >> (7 * n)) != 16'd0) n++;
    repeat (pad) vlu_b.insert(vlu_b.size(), 8'h80);
    for (k = n - 1; k >= 0; k--) begin
      g = v >> (7 * k);
      vlu_b.insert(vlu_b.size(), {k != 0, g[6:0]});
    end
  endtask

  task automatic flush_list();
    kolp_pkg::in_word_t w;
    while (list_b.size() != 0) begin
      w.data_byte = list_b.pop_front();
      w.last_byte = (list_b.size() == 0);
      word_q.insert(word_q.size(), w);
    end
  endtask

  task automatic queue_fixed(input logic [95:0] bytes, input int n);
    int k;
    for (k = 0; k < n; k++) list_b.insert(list_b.size(), bytes[8 * (n - 1 - k) +: 8]);
    flush_list();
  endtask

  task automatic build_option();
    int kind;
    int pick;
    int pad;
    logic [15:0] tval;
    logic [15:0] hlen;
    logic [15:0] olen;
    logic [7:0] r;
    typ_b.delete();
    val_b.delete();
    kind = $urandom_range(0, 5);
    pad = ($urandom_range(0, 7) == 0) ? 1 : 0;
    if (kind <= 1) begin
      tval = kolp_pkg::TYPE_HMAC;
      if ($urandom_range(0, 9) != 0) begin
        r = 8'($urandom_range(0, 255));
        val_b.insert(val_b.size(), r);
        pick = $urandom_range(0, 7);
        case (pick)
          0: ;
          1: begin
            r = 8'($urandom_range(128, 255));
            val_b.insert(val_b.size(), r);
          end
          2: begin
            val_b.insert(val_b.size(), 8'hff);
            val_b.insert(val_b.size(), 8'hff);
            val_b.insert(val_b.size(), 8'h7f);
          end
          default: begin
            if (pick == 3) hlen = 16'($urandom_range(0, 3));
            else if (pick == 7) hlen = 16'($urandom_range(33, 65535));
            else hlen = 16'($urandom_range(4, 32));
            enc_vlu(hlen, ($urandom_range(0, 3) == 0) ? 1 : 0);
            foreach (vlu_b[i]) val_b.insert(val_b.size(), vlu_b[i]);
          end
        endcase
      end
    end else if (kind <= 3) begin
      tval = kolp_pkg::TYPE_SSEQ;
      if ($urandom_range(0, 9) != 0) begin
        r = 8'($urandom_range(0, 255));
        val_b.insert(val_b.size(), r);
      end
    end else begin
      if ($urandom_range(0, 1) == 0) tval = 16'($urandom_range(0, 127));
      else tval = 16'($urandom_range(0, 65535));
      repeat ($urandom_range(0, 4)) begin
        r = 8'($urandom_range(0, 255));
        val_b.insert(val_b.size(), r);
      end
    end
    if (kind <= 3 && val_b.size() != 0 && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        r = 8'($urandom_range(0, 255));
        val_b.insert(val_b.size(), r);
      end
    end
    if (kind > 3 && $urandom_range(0, 7) == 0) begin
      typ_b.insert(typ_b.size(), 8'hff);
      typ_b.insert(typ_b.size(), 8'hff);
      typ_b.insert(typ_b.size(), 8'h7f);
    end else begin
      enc_vlu(tval, pad);
      foreach (vlu_b[i]) typ_b.insert(typ_b.size(), vlu_b[i]);
    end
    olen = 16'(typ_b.size() + val_b.size());
    // broken framing now and then
    if ($urandom_range(0, 11) == 0) olen = 16'($urandom_range(1, olen));
    enc_vlu(olen, ($urandom_range(0, 7) == 0) ? 1 : 0);
    foreach (vlu_b[i]) list_b.insert(list_b.size(), vlu_b[i]);
    foreach (typ_b[i]) list_b.insert(list_b.size(), typ_b[i]);
    foreach (val_b[i]) list_b.insert(list_b.size(), val_b[i]);
  endtask

  task automatic build_random_list();
    int mode;
    int cut;
    logic [7:0] r;
    mode = $urandom_range(0, 9);
    if (mode >= 8) begin
      repeat ($urandom_range(1, 12)) begin
        r = 8'($urandom_range(0, 255));
        list_b.insert(list_b.size(), r);
      end
    end else begin
      repeat ($urandom_range(0, 4)) build_option();
      if ($urandom_range(0, 2) != 0) begin
        list_b.insert(list_b.size(), 8'h00);
        repeat ($urandom_range(0, 3)) begin
          r = 8'($urandom_range(0, 255));
          list_b.insert(list_b.size(), r);
        end
      end
      if (mode == 7 && list_b.size() > 1) begin
        cut = $urandom_range(1, list_b.size() - 1);
        while (list_b.size() > cut) r = list_b.pop_back();
      end
      if (list_b.size() == 0) list_b.insert(list_b.size(), 8'h00);
    end
    flush_list();
  endtask

  task automatic send_words();
    int burst;
    int gap;
    burst = 0;
    while (word_q.size() != 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst--;
      in_valid <= 1'b1;
      in_data  <= word_q.pop_front();
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin : receiver
    int mode;
    int span;
    mode = 0;
    span = 0;
    out_ready <= 1'b0;
    forever begin
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(5, 60);
      end
      span--;
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int ph;
    logic [7:0] cfg_val;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hmac + sseq, end marker, ignored tail
    queue_fixed(96'h031a0520021eff00ab, 9);
    // saturated hmac length, empty value, type longer than length
    queue_fixed(96'h051a01ffff7f011e019a1aff, 12);
    // hmac length runs past value end
    queue_fixed(96'h031a048500, 5);
    // truncated option
    queue_fixed(96'h031a05, 3);
    send_words();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: cfg_val = 8'd255;
        1: cfg_val = 8'd1;
        2: cfg_val = 8'd0;
        4: cfg_val = 8'd4;
        default: cfg_val = 8'($urandom_range(0, 255));
      endcase
      cfg_valid <= 1'b1;
      cfg_data  <= cfg_val;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      while (word_q.size() < PHASE_WORDS) build_random_list();
      if (ph == 0) hold_req = 1'b1;
      send_words();
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/kolp_pkg.sv
rtl/core/kolp_parser.sv
rtl/core/keying_option_list_parser.sv
test/option_report_checker.sv
test/testbench.sv
